/* hw/rtl/jbfp_pkg.sv */
// Package for the joystick/button frame parser.
// Holds the event codes, the framing and decode constants, and the
// three-digit decode helper. No dependencies.
package jbfp_pkg;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_BUTTON = 2'd1,
    EV_JOY    = 2'd2,
    EV_ERROR  = 2'd3
  } ev_t;

  localparam logic [7:0] STX_CODE = 8'h02;
  localparam logic [7:0] ETX_CODE = 8'h03;

  // frame positions
  localparam logic [3:0] POS_IDLE   = 4'd0;
  localparam logic [3:0] POS_BUTTON = 4'd2;
  localparam logic [3:0] POS_JOY    = 4'd7;
  localparam logic [3:0] POS_LAST   = 4'd6;

  localparam int NUM_BYTES = 6;

  localparam logic [6:0] CODE_A = 7'd65;
  localparam logic [6:0] CODE_L = 7'd76;

  localparam logic signed [14:0] ASCII_ZERO = 15'sd48;
  localparam logic signed [14:0] JOY_OFFSET = 15'sd200;
  localparam logic signed [14:0] JOY_LIMIT  = 15'sd100;

  typedef logic [6:0] fbyte_t;
  typedef logic signed [14:0] joy_t;

  // (c0-48)*100 + (c1-48)*10 + (c2-48) - 200 on raw 7-bit codes
  function automatic joy_t three_digits(input fbyte_t c0, input fbyte_t c1,
                                        input fbyte_t c2);
    joy_t d0;
    joy_t d1;
    joy_t d2;
    d0 = $signed({8'b0, c0}) - ASCII_ZERO;
    d1 = $signed({8'b0, c1}) - ASCII_ZERO;
    d2 = $signed({8'b0, c2}) - ASCII_ZERO;
    return d0 * 15'sd100 + d1 * 15'sd10 + d2 - JOY_OFFSET;
  endfunction

endpackage

/* hw/rtl/jbfp_if.sv */
// Channel interfaces for the joystick/button frame parser.
// jbfp_in_if carries received bytes, jbfp_out_if carries results.
// No dependencies.
interface jbfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface jbfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_event;
  logic [5:0]  button_bits;
  logic        led_on;
  logic signed [7:0] steer_value;
  logic signed [7:0] speed_value;

  modport source (output valid, output frame_event, output button_bits, output led_on,
                  output steer_value, output speed_value, input ready);
  modport sink   (input valid, input frame_event, input button_bits, input led_on,
                  input steer_value, input speed_value, output ready);
endinterface

/* hw/rtl/jbfp_in_stage.sv */
// Input register stage: captures one received byte per request.
// Depends on jbfp_pkg.
module jbfp_in_stage
  import jbfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,       // core consumes the held byte this cycle
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

/* hw/rtl/jbfp_core.sv */
// Frame parser core: frame position, byte store, button and joystick
// state, and the result register. Depends on jbfp_pkg.
module jbfp_core
  import jbfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       held_valid,
  input  logic [7:0] held_byte,
  output logic       take,
  output logic       out_valid,
  input  logic       out_ready,
  output ev_t        out_event,
  output logic [5:0] out_buttons,
  output logic       out_led,
  output logic signed [7:0] out_steer,
  output logic signed [7:0] out_speed
);

  logic [3:0]        pos_r, pos_nxt;
  fbyte_t            bytes_r [NUM_BYTES];
  logic [5:0]        btn_r, btn_nxt;
  logic signed [7:0] steer_r, steer_nxt;
  logic signed [7:0] speed_r, speed_nxt;
  logic              wr_en;
  logic [2:0]        wr_idx;
  ev_t               ev;
  logic              res_valid_r;
  ev_t               res_event_r;
  logic [5:0]        res_btn_r;
  logic signed [7:0] res_steer_r, res_speed_r;
  joy_t              steer_v, speed_v;
  logic              joy_ok;
  logic [3:0]        k;
  logic [5:0]        bit_mask;

  assign take = held_valid && (!res_valid_r || out_ready);

  assign steer_v = three_digits(bytes_r[0], bytes_r[1], bytes_r[2]);
  assign speed_v = three_digits(bytes_r[3], bytes_r[4], bytes_r[5]);
  assign joy_ok  = (steer_v >= -JOY_LIMIT) && (steer_v <= JOY_LIMIT) &&
                   (speed_v >= -JOY_LIMIT) && (speed_v <= JOY_LIMIT);

  // A,C,E,.. set a bit; B,D,F,.. clear it
  assign k        = 4'(bytes_r[0] - CODE_A);
  assign bit_mask = 6'(6'd1 << k[3:1]);

  always_comb begin
    pos_nxt   = pos_r;
    btn_nxt   = btn_r;
    steer_nxt = steer_r;
    speed_nxt = speed_r;
    ev        = EV_NONE;
    wr_en     = 1'b0;
    wr_idx    = 3'(pos_r - 4'd1);
    if (pos_r == POS_IDLE) begin
      if (held_byte == STX_CODE) begin
        pos_nxt = 4'd1;
      end
    end else if (held_byte[7] || pos_r > POS_JOY) begin
      ev      = EV_ERROR;
      pos_nxt = POS_IDLE;
    end else if (held_byte == ETX_CODE && pos_r == POS_BUTTON) begin
      ev      = EV_BUTTON;
      pos_nxt = POS_IDLE;
      if (bytes_r[0] inside {[CODE_A:CODE_L]}) begin
        if (!k[0]) begin
          btn_nxt = btn_r | bit_mask;
        end else begin
          btn_nxt = btn_r & ~bit_mask;
        end
      end
    end else if (held_byte == ETX_CODE && pos_r == POS_JOY) begin
      pos_nxt = POS_IDLE;
      if (joy_ok) begin
        ev        = EV_JOY;
        steer_nxt = steer_v[7:0];
        speed_nxt = speed_v[7:0];
      end else begin
        ev = EV_ERROR;
      end
    end else begin
      wr_en   = (pos_r <= POS_LAST);
      pos_nxt = pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_IDLE;
      btn_r       <= '0;
      steer_r     <= '0;
      speed_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (take) begin
        pos_r   <= pos_nxt;
        btn_r   <= btn_nxt;
        steer_r <= steer_nxt;
        speed_r <= speed_nxt;
      end
      if (take) begin
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      bytes_r[wr_idx] <= held_byte[6:0];
    end
    if (take) begin
      res_event_r <= ev;
      res_btn_r   <= btn_nxt;
      res_steer_r <= steer_nxt;
      res_speed_r <= speed_nxt;
    end
  end

  assign out_valid   = res_valid_r;
  assign out_event   = res_event_r;
  assign out_buttons = res_btn_r;
  assign out_led     = res_btn_r[0];
  assign out_steer   = res_steer_r;
  assign out_speed   = res_speed_r;

endmodule

/* hw/rtl/joystick_button_frame_parser.sv */
// Joystick/button frame parser, top level.
// An accepted byte reaches its result through the input register, then the
// result register. Throughput: one byte per cycle unless the result channel
// stalls; each byte gives exactly one result. Synchronous active-low reset
// returns the parser to idle and clears buttons, steer and speed.
module joystick_button_frame_parser
  import jbfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  jbfp_in_if.sink    in_ch,
  jbfp_out_if.source out_ch
);

  logic       take;
  logic       held_valid;
  logic [7:0] held_byte;
  ev_t        out_event;

  jbfp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  jbfp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .held_valid  (held_valid),
    .held_byte   (held_byte),
    .take        (take),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_event   (out_event),
    .out_buttons (out_ch.button_bits),
    .out_led     (out_ch.led_on),
    .out_steer   (out_ch.steer_value),
    .out_speed   (out_ch.speed_value)
  );

  assign out_ch.frame_event = out_event;

endmodule

/* test/joystick_button_frame_parser_tb.sv */
// Testbench for joystick_button_frame_parser: directed and random byte streams,
// checked against a cycle-free parser model with random stalls on both channels.
// Depends on jbfp_pkg, jbfp_if.sv and the parser RTL.
module joystick_button_frame_parser_tb;
  import jbfp_pkg::*;

  localparam logic [7:0] MAX_DATA       = 8'd127;
  localparam int         RANDOM_BYTES   = 1300;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         DRAIN_CYCLES   = 10;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         MAX_REPORTS    = 10;

  typedef struct packed {
    ev_t              ev;
    logic [5:0]       buttons;
    logic             led;
    logic [7:0]       steer;
    logic [7:0]       speed;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n;

  jbfp_in_if  in_ch();
  jbfp_out_if out_ch();

  joystick_button_frame_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // parser model state
  logic [3:0] model_pos;
  fbyte_t     model_buf [NUM_BYTES];
  logic [5:0] model_buttons;
  logic [7:0] model_steer;
  logic [7:0] model_speed;

  parse_result_t expected_results[$];
  logic [7:0]    tx_bytes[$];

  int  mismatches;
  int  bytes_accepted;
  int  seen_button;
  int  seen_joy;
  int  seen_error;
  int  seen_none;
  bit  gaps_on;
  bit  hold_req;

  function automatic int digits_value(input fbyte_t c0, input fbyte_t c1, input fbyte_t c2);
    int zero;
    zero = int'(ASCII_ZERO);
    return (int'(c0) - zero) * 100 + (int'(c1) - zero) * 10 + (int'(c2) - zero)
           - int'(JOY_OFFSET);
  endfunction

  function automatic void apply_button_code(input fbyte_t code);
    int         k;
    logic [5:0] mask;
    if (code >= CODE_A && code <= CODE_L) begin
      k = int'(code) - int'(CODE_A);
      mask = 6'b000001 << (k >> 1);
      if ((k & 1) == 0) begin
        model_buttons = model_buttons | mask;
      end else begin
        model_buttons = model_buttons & ~mask;
      end
    end
  endfunction

  function automatic parse_result_t predict_byte(input logic [7:0] b);
    parse_result_t r;
    ev_t           ev;
    int            st;
    int            sp;
    int            lim;
    ev = EV_NONE;
    lim = int'(JOY_LIMIT);
    if (model_pos == POS_IDLE) begin
      if (b == STX_CODE) model_pos = 4'd1;
    end else if (b > MAX_DATA || model_pos > POS_JOY) begin
      ev = EV_ERROR;
      model_pos = POS_IDLE;
    end else if (b == ETX_CODE && model_pos == POS_BUTTON) begin
      apply_button_code(model_buf[0]);
      ev = EV_BUTTON;
      model_pos = POS_IDLE;
    end else if (b == ETX_CODE && model_pos == POS_JOY) begin
      st = digits_value(model_buf[0], model_buf[1], model_buf[2]);
      sp = digits_value(model_buf[3], model_buf[4], model_buf[5]);
      if (st < -lim || st > lim || sp < -lim || sp > lim) begin
        ev = EV_ERROR;
      end else begin
        model_steer = st[7:0];
        model_speed = sp[7:0];
        ev = EV_JOY;
      end
      model_pos = POS_IDLE;
    end else begin
      // position 7 with a non-end byte is not stored
      if (model_pos <= POS_LAST) model_buf[model_pos - 4'd1] = b[6:0];
      model_pos = model_pos + 4'd1;
    end
    r.ev      = ev;
    r.buttons = model_buttons;
    r.led     = model_buttons[0];
    r.steer   = model_steer;
    r.speed   = model_speed;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    bit took;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    // ready only moves at the rising edge, so the mid-cycle value is what the edge sees
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    expected_results.push_back(predict_byte(b));
    bytes_accepted++;
  endtask

  task automatic flush_tx();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  task automatic push_button_frame(input logic [6:0] code);
    tx_bytes.push_back(STX_CODE);
    tx_bytes.push_back({1'b0, code});
    tx_bytes.push_back(ETX_CODE);
  endtask

  task automatic push_joy_value();
    int v;
    int n;
    if ($urandom_range(0, 9) == 0) begin
      // raw 7-bit codes, not built from a value
      repeat (3) tx_bytes.push_back(8'($urandom_range(0, 127)));
    end else begin
      case ($urandom_range(0, 19))
        0:       v = -100;
        1:       v = 100;
        2:       v = -101;
        3:       v = 101;
        default: v = $urandom_range(0, 220) - 110;
      endcase
      n = v + int'(JOY_OFFSET);
      tx_bytes.push_back(8'(n / 100 + int'(ASCII_ZERO)));
      tx_bytes.push_back(8'((n / 10) % 10 + int'(ASCII_ZERO)));
      tx_bytes.push_back(8'(n % 10 + int'(ASCII_ZERO)));
    end
  endtask

  task automatic push_joy_frame();
    tx_bytes.push_back(STX_CODE);
    push_joy_value();
    push_joy_value();
    tx_bytes.push_back(ETX_CODE);
  endtask

  task automatic push_digits(input string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(8'(s[i]));
  endtask

  // ---------------- tests ----------------

  task automatic test_idle_bytes();
    tx_bytes = '{8'hFF, 8'h00, ETX_CODE};
    flush_tx();
  endtask

  task automatic test_button_frames();
    push_button_frame(CODE_A);
    // start byte inside a frame is data, and an unknown code still reports
    push_button_frame(STX_CODE[6:0]);
    flush_tx();
  endtask

  task automatic test_joystick_extremes();
    tx_bytes.push_back(STX_CODE);
    push_digits("300100");
    tx_bytes.push_back(ETX_CODE);
    flush_tx();
  endtask

  task automatic test_frame_errors();
    tx_bytes = '{STX_CODE, 8'h80};
    // end byte at position 3 is data, 'x' at position 7 skipped, ninth byte aborts
    tx_bytes.push_back(STX_CODE);
    push_digits("12");
    tx_bytes.push_back(ETX_CODE);
    push_digits("456x");
    tx_bytes.push_back(ETX_CODE);
    flush_tx();
  endtask

  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (5) push_button_frame(CODE_A + 7'($urandom_range(0, 11)));
    repeat (3) push_joy_frame();
    flush_tx();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int sent;
    int kind;
    int k;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 99) < 8) gaps_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 85 && model_pos != POS_IDLE && $urandom_range(0, 9) < 8) begin
        // abort a leftover frame so that the next one starts clean
        tx_bytes.push_back(8'($urandom_range(128, 255)));
      end
      if (kind < 30) begin
        if ($urandom_range(0, 3) != 0) push_button_frame(CODE_A + 7'($urandom_range(0, 11)));
        else push_button_frame(7'($urandom_range(0, 127)));
      end else if (kind < 70) begin
        push_joy_frame();
      end else if (kind < 85) begin
        tx_bytes.push_back(STX_CODE);
        k = $urandom_range(0, 9);
        repeat (k) begin
          if ($urandom_range(0, 9) != 0) tx_bytes.push_back(8'($urandom_range(0, 127)));
          else tx_bytes.push_back(8'($urandom_range(128, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(0, 255)));
        sent += tx_bytes.size();
        flush_tx();
        continue;
      end
      sent += tx_bytes.size();
      flush_tx();
    end
    gaps_on = 1'b1;
  endtask

  // ---------------- result side ----------------

  initial begin
    int low_left;
    int high_left;
    low_left = 0;
    high_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        low_left = HOLD_CYCLES;
        high_left = 0;
      end
      if (low_left > 0) begin
        out_ch.ready <= 1'b0;
        low_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (high_left > 0) begin
          high_left--;
        end else begin
          high_left = $urandom_range(0, 30);
          low_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.ev      = ev_t'(out_ch.frame_event);
      got.buttons = out_ch.button_bits;
      got.led     = out_ch.led_on;
      got.steer   = out_ch.steer_value;
      got.speed   = out_ch.speed_value;
      case (got.ev)
        EV_BUTTON: seen_button++;
        EV_JOY:    seen_joy++;
        EV_ERROR:  seen_error++;
        default:   seen_none++;
      endcase
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: event %0d buttons %b", got.ev, got.buttons);
      end else begin
        want = expected_results.pop_front();
        if (got.ev !== want.ev || got.buttons !== want.buttons || got.led !== want.led ||
            got.steer !== want.steer || got.speed !== want.speed) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected ev %0d btn %b led %b steer %0d speed %0d",
                     want.ev, want.buttons, want.led, $signed(want.steer), $signed(want.speed));
            $display("          actual   ev %0d btn %b led %b steer %0d speed %0d",
                     got.ev, got.buttons, got.led, $signed(got.steer), $signed(got.speed));
          end
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves a request
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("joystick_button_frame_parser verification failed");
        $finish;
      end
    end
  end

  initial begin
    model_pos     = POS_IDLE;
    model_buttons = '0;
    model_steer   = '0;
    model_speed   = '0;
    for (int i = 0; i < NUM_BYTES; i++) model_buf[i] = '0;
    mismatches     = 0;
    bytes_accepted = 0;
    seen_button    = 0;
    seen_joy       = 0;
    seen_error     = 0;
    seen_none      = 0;
    gaps_on        = 1'b1;
    hold_req       = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_bytes();
    test_button_frames();
    test_joystick_extremes();
    test_frame_errors();
    test_backpressure();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes sent, results: %0d button, %0d joystick, %0d error, %0d idle/partial",
             bytes_accepted, seen_button, seen_joy, seen_error, seen_none);
    $display("with random gaps on both channels and a %0d-cycle output hold", HOLD_CYCLES);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("joystick_button_frame_parser verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("joystick_button_frame_parser verification failed");
    end
    $finish;
  end

endmodule
